// ===== hdl/mrr_pkg.sv =====
package mrr_pkg;
  localparam int MAX_CORES = 4;
  localparam int MAX_TASKS = 32;
  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = 2;
  localparam int IDW = 16;
  localparam int QW = 16;
  localparam int TCW = SW + 1;

  localparam logic [2:0] MODE_LOAD    = 3'd0;
  localparam logic [2:0] MODE_UNBLOCK = 3'd1;
  localparam logic [2:0] MODE_TICK    = 3'd2;
  localparam logic [2:0] MODE_BLOCK   = 3'd3;
  localparam logic [2:0] MODE_EXIT    = 3'd4;

  localparam logic [2:0] ST_READY   = 3'd6;
  localparam logic [2:0] ST_BLOCKED = 3'd7;

  localparam logic [2:0] REG_CORE_COUNT = 3'd0;

  typedef logic [SW-1:0] slot_t;
endpackage

// ===== hdl/multicore_round_robin_scheduler.sv =====
// An unused core, or an idle core on an empty ring, strobes a result in the cycle after
// acceptance; a tick within its slice strobes after the slot read, a dispatch or exit after the ring walk.
// One transaction is taken at a time (busy is high until it is done); the ring walk reads
// one slot per cycle (up to MAX_TASKS slots); a load writes the head, successor and new slot.
// Reset (rst_n low, synchronous) empties the ring, idles all cores and restores core_count
// 1 and every quantum and slice to 1. The receiver cannot stall.
module multicore_round_robin_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_task_id,
  input  logic [1:0]  in_core,
  output logic        out_valid,
  output logic [1:0]  out_core,
  output logic [15:0] out_running_id,
  output logic        out_idle,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOADA  = 4'd1;   // head record read
  localparam logic [3:0] S_LOADB  = 4'd2;   // old successor read
  localparam logic [3:0] S_LOADC  = 4'd3;   // write new record
  localparam logic [3:0] S_UNBLK  = 4'd4;   // unblock scan
  localparam logic [3:0] S_TICK   = 4'd5;   // current slot read
  localparam logic [3:0] S_DSTART = 4'd6;   // dispatch from head: head read
  localparam logic [3:0] S_DWALK  = 4'd7;   // dispatch: test slot p
  localparam logic [3:0] S_EXA    = 4'd8;   // exit: current slot read
  localparam logic [3:0] S_EXB    = 4'd9;   // exit: successor read
  localparam logic [3:0] S_EXC    = 4'd10;  // exit: predecessor read

  // slot memory: {task, next, prev, status}
  localparam int EW = mrr_pkg::IDW + 2*mrr_pkg::SW + 3;
  logic [EW-1:0] mem [mrr_pkg::MAX_TASKS];
  logic [EW-1:0] rd_q;
  mrr_pkg::slot_t rd_addr;
  logic          wr_en;
  mrr_pkg::slot_t wr_addr;
  logic [EW-1:0] wr_data;

  // write first when the same entry is read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == rd_addr) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  logic [mrr_pkg::IDW-1:0] q_task;
  mrr_pkg::slot_t          q_next, q_prev;
  logic [2:0]              q_stat;
  assign {q_task, q_next, q_prev, q_stat} = rd_q;

  logic [3:0] state_r, state_nxt;
  logic [2:0] cc_r, cc_nxt;
  logic [mrr_pkg::QW-1:0] quant_r [mrr_pkg::MAX_CORES];
  logic [mrr_pkg::QW-1:0] quant_nxt [mrr_pkg::MAX_CORES];
  logic [mrr_pkg::QW-1:0] slice_r [mrr_pkg::MAX_CORES];
  logic [mrr_pkg::QW-1:0] slice_nxt [mrr_pkg::MAX_CORES];
  logic [mrr_pkg::MAX_CORES-1:0] cbusy_r, cbusy_nxt;
  mrr_pkg::slot_t cslot_r [mrr_pkg::MAX_CORES];
  mrr_pkg::slot_t cslot_nxt [mrr_pkg::MAX_CORES];
  logic [mrr_pkg::MAX_TASKS-1:0] used_r, used_nxt;
  mrr_pkg::slot_t head_r, head_nxt;
  logic [mrr_pkg::TCW-1:0] total_r, total_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [15:0] id_r, id_nxt;
  logic [1:0] core_r, core_nxt;
  mrr_pkg::slot_t from_r, from_nxt;
  mrr_pkg::slot_t p_r, p_nxt;
  mrr_pkg::slot_t n_r, n_nxt;
  mrr_pkg::slot_t nx_r, nx_nxt;
  mrr_pkg::slot_t pv_r, pv_nxt;
  mrr_pkg::slot_t nn_r, nn_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_core_r, out_core_nxt;
  logic [15:0] out_id_r, out_id_nxt;
  logic        out_idle_r, out_idle_nxt;

  logic [2:0] ncores;
  assign ncores = (cc_r > 3'(mrr_pkg::MAX_CORES)) ? 3'(mrr_pkg::MAX_CORES) : cc_r;

  mrr_pkg::slot_t cur_s;
  assign cur_s = cslot_r[core_r];

  // first free slot and first idle core
  mrr_pkg::slot_t free_s;
  logic [1:0] idle_c;
  logic idle_f;
  logic [2:0] new_st;
  always_comb begin
    free_s = '0;
    for (int i = mrr_pkg::MAX_TASKS - 1; i >= 0; i--) begin
      if (!used_r[i]) free_s = mrr_pkg::slot_t'(i);
    end
    idle_f = 1'b0;
    idle_c = '0;
    for (int i = mrr_pkg::MAX_CORES - 1; i >= 0; i--) begin
      if (!cbusy_r[i] && 3'(i) < ncores) begin
        idle_f = 1'b1;
        idle_c = 2'(i);
      end
    end
    new_st = idle_f ? {1'b0, idle_c} : mrr_pkg::ST_READY;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_core = out_core_r;
  assign out_running_id = out_id_r;
  assign out_idle = out_idle_r;

  function automatic logic [EW-1:0] set_stat(logic [EW-1:0] e, logic [2:0] st);
    return {e[EW-1:3], st};
  endfunction

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cc_nxt = cc_r;
    quant_nxt = quant_r;
    slice_nxt = slice_r;
    cbusy_nxt = cbusy_r;
    cslot_nxt = cslot_r;
    used_nxt = used_r;
    head_nxt = head_r;
    total_nxt = total_r;
    mode_nxt = mode_r;
    id_nxt = id_r;
    core_nxt = core_r;
    from_nxt = from_r;
    p_nxt = p_r;
    n_nxt = n_r;
    nx_nxt = nx_r;
    pv_nxt = pv_r;
    nn_nxt = nn_r;
    out_valid_nxt = 1'b0;
    out_core_nxt = out_core_r;
    out_id_nxt = out_id_r;
    out_idle_nxt = out_idle_r;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    // take register writes
    if (cfg_we) begin
      if (cfg_index == mrr_pkg::REG_CORE_COUNT) begin
        cc_nxt = cfg_data[2:0];
      end else if (cfg_index <= 3'(mrr_pkg::MAX_CORES)) begin
        quant_nxt[2'(cfg_index - 3'd1)] = cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          id_nxt = in_task_id;
          core_nxt = in_core;
          out_core_nxt = in_core;
          if (in_mode == mrr_pkg::MODE_LOAD) begin
            if (total_r == '0) begin
              // empty ring: the new task links to itself
              wr_en = 1'b1;
              wr_addr = free_s;
              wr_data = {in_task_id, free_s, free_s, new_st};
              used_nxt[free_s] = 1'b1;
              head_nxt = free_s;
              total_nxt = total_r + mrr_pkg::TCW'(1);
              if (idle_f) begin
                cbusy_nxt[idle_c] = 1'b1;
                cslot_nxt[idle_c] = free_s;
              end
            end else if (total_r < mrr_pkg::TCW'(mrr_pkg::MAX_TASKS)) begin
              rd_addr = head_r;
              state_nxt = S_LOADA;
            end
          end else if (in_mode == mrr_pkg::MODE_UNBLOCK) begin
            rd_addr = '0;
            n_nxt = '0;
            state_nxt = S_UNBLK;
          end else if (in_mode inside {mrr_pkg::MODE_TICK, mrr_pkg::MODE_BLOCK,
                                       mrr_pkg::MODE_EXIT}) begin
            if (3'(in_core) >= ncores || (!cbusy_r[in_core] && total_r == '0)) begin
              // core out of use, or nothing to dispatch
              out_valid_nxt = 1'b1;
              out_id_nxt = '0;
              out_idle_nxt = 1'b1;
            end else if (!cbusy_r[in_core]) begin
              rd_addr = head_r;
              state_nxt = S_DSTART;
            end else begin
              rd_addr = cslot_r[in_core];
              state_nxt = (in_mode == mrr_pkg::MODE_EXIT) ? S_EXA : S_TICK;
            end
          end
        end
      end
      S_LOADA: begin
        // link the new slot after the head
        nx_nxt = q_next;
        wr_en = 1'b1;
        wr_addr = head_r;
        wr_data = {q_task, free_s, q_prev, q_stat};
        rd_addr = q_next;
        state_nxt = S_LOADB;
      end
      S_LOADB: begin
        // old successor, forwarded when it is the head itself
        wr_en = 1'b1;
        wr_addr = nx_r;
        wr_data = {q_task, q_next, free_s, q_stat};
        state_nxt = S_LOADC;
      end
      S_LOADC: begin
        wr_en = 1'b1;
        wr_addr = free_s;
        wr_data = {id_r, nx_r, head_r, new_st};
        used_nxt[free_s] = 1'b1;
        total_nxt = total_r + mrr_pkg::TCW'(1);
        if (idle_f) begin
          cbusy_nxt[idle_c] = 1'b1;
          cslot_nxt[idle_c] = free_s;
        end
        state_nxt = S_IDLE;
      end
      S_UNBLK: begin
        // rd_q holds slot n_r
        if (used_r[n_r] && q_task == id_r && q_stat == mrr_pkg::ST_BLOCKED) begin
          wr_en = 1'b1;
          wr_addr = n_r;
          wr_data = set_stat(rd_q, mrr_pkg::ST_READY);
          state_nxt = S_IDLE;
        end else if (n_r == mrr_pkg::slot_t'(mrr_pkg::MAX_TASKS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          n_nxt = n_r + mrr_pkg::slot_t'(1);
          rd_addr = n_r + mrr_pkg::slot_t'(1);
        end
      end
      S_TICK: begin
        if (mode_r == mrr_pkg::MODE_TICK && slice_r[core_r] != '0) begin
          slice_nxt[core_r] = slice_r[core_r] - 16'd1;
          out_valid_nxt = 1'b1;
          out_id_nxt = q_task;
          out_idle_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          // park the task and walk on from it; an expired tick still counts down
          wr_en = 1'b1;
          wr_addr = cur_s;
          wr_data = set_stat(rd_q, (mode_r == mrr_pkg::MODE_TICK) ?
                                   mrr_pkg::ST_READY : mrr_pkg::ST_BLOCKED);
          slice_nxt[core_r] = (mode_r == mrr_pkg::MODE_TICK) ?
                              quant_r[core_r] - 16'd1 : quant_r[core_r];
          from_nxt = cur_s;
          p_nxt = q_next;
          n_nxt = '0;
          rd_addr = q_next;
          state_nxt = S_DWALK;
        end
      end
      S_DSTART: begin
        // idle core: walk from the head
        slice_nxt[core_r] = quant_r[core_r];
        from_nxt = head_r;
        p_nxt = q_next;
        n_nxt = '0;
        rd_addr = q_next;
        state_nxt = S_DWALK;
      end
      S_DWALK: begin
        // rd_q holds slot p_r
        if (q_stat == mrr_pkg::ST_READY) begin
          wr_en = 1'b1;
          wr_addr = p_r;
          wr_data = set_stat(rd_q, {1'b0, core_r});
          cbusy_nxt[core_r] = 1'b1;
          cslot_nxt[core_r] = p_r;
          out_valid_nxt = 1'b1;
          out_id_nxt = q_task;
          out_idle_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else if (p_r == from_r || n_r == mrr_pkg::slot_t'(mrr_pkg::MAX_TASKS - 1)) begin
          cbusy_nxt[core_r] = 1'b0;
          out_valid_nxt = 1'b1;
          out_id_nxt = '0;
          out_idle_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          p_nxt = q_next;
          n_nxt = n_r + mrr_pkg::slot_t'(1);
          rd_addr = q_next;
        end
      end
      S_EXA: begin
        // hold the neighbours of the leaving task
        pv_nxt = q_prev;
        nx_nxt = q_next;
        rd_addr = q_next;
        state_nxt = S_EXB;
      end
      S_EXB: begin
        // successor: prev = pv
        wr_en = 1'b1;
        wr_addr = nx_r;
        wr_data = {q_task, q_next, pv_r, q_stat};
        nn_nxt = q_next;
        rd_addr = pv_r;
        state_nxt = S_EXC;
      end
      S_EXC: begin
        // predecessor: next = nx, then drop the task and walk from its successor
        wr_en = 1'b1;
        wr_addr = pv_r;
        wr_data = {q_task, nx_r, q_prev, q_stat};
        if (head_r == cur_s) head_nxt = nx_r;
        used_nxt[cur_s] = 1'b0;
        total_nxt = total_r - mrr_pkg::TCW'(1);
        slice_nxt[core_r] = quant_r[core_r];
        from_nxt = nx_r;
        rd_addr = (pv_r == nx_r) ? nx_r : nn_r;
        p_nxt = rd_addr;
        n_nxt = '0;
        state_nxt = S_DWALK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cc_r <= 3'd1;
      for (int i = 0; i < mrr_pkg::MAX_CORES; i++) begin
        quant_r[i] <= 16'd1;
        slice_r[i] <= 16'd1;
        cslot_r[i] <= '0;
      end
      cbusy_r <= '0;
      used_r <= '0;
      head_r <= '0;
      total_r <= '0;
      mode_r <= '0;
      id_r <= '0;
      core_r <= '0;
      from_r <= '0;
      p_r <= '0;
      n_r <= '0;
      nx_r <= '0;
      pv_r <= '0;
      nn_r <= '0;
      out_valid_r <= 1'b0;
      out_core_r <= '0;
      out_id_r <= '0;
      out_idle_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cc_r <= cc_nxt;
      quant_r <= quant_nxt;
      slice_r <= slice_nxt;
      cslot_r <= cslot_nxt;
      cbusy_r <= cbusy_nxt;
      used_r <= used_nxt;
      head_r <= head_nxt;
      total_r <= total_nxt;
      mode_r <= mode_nxt;
      id_r <= id_nxt;
      core_r <= core_nxt;
      from_r <= from_nxt;
      p_r <= p_nxt;
      n_r <= n_nxt;
      nx_r <= nx_nxt;
      pv_r <= pv_nxt;
      nn_r <= nn_nxt;
      out_valid_r <= out_valid_nxt;
      out_core_r <= out_core_nxt;
      out_id_r <= out_id_nxt;
      out_idle_r <= out_idle_nxt;
    end
  end
endmodule
